FILE: src/pcrg_pkg.sv
// Package for the pinhole camera ray generator: widths, codes, reset values
// and the subpixel sample tables. Used by the interfaces and the top level.
// No dependencies.
`default_nettype none

package pcrg_pkg;

  // Default values for the top-level parameters.
  localparam int MaxDimDefault   = 4096;
  localparam int AxisFracDefault = 19;

  // Field widths.
  localparam int OpW      = 2;
  localparam int CoordW   = 12;
  localparam int DimW     = 13;
  localparam int ScaleW   = 24;
  localparam int CompW    = 21;
  localparam int AxisW    = 3 * CompW;
  localparam int DirW     = 32;
  localparam int IdxW     = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 63;

  // Internal arithmetic widths.
  localparam int PosW      = 17;               // u or v in eighths of a pixel
  localparam int ProdW     = ScaleW + 1 + PosW; // scale times position
  localparam int SumW      = 64;
  localparam int ScaleFrac = 20;
  localparam int SubFrac   = 3;
  localparam int BackShift = ScaleFrac + SubFrac;

  // Request modes.
  localparam logic [OpW-1:0] OP_CENTRE = 2'd0;
  localparam logic [OpW-1:0] OP_CORNER = 2'd1;
  localparam logic [OpW-1:0] OP_GRID   = 2'd2;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VIEW_SCALE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_AXIS_RIGHT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AXIS_UP      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AXIS_BACK    = 3'd5;

  // Register reset values.
  localparam logic [DimW-1:0]   WidthReset  = 13'd640;
  localparam logic [DimW-1:0]   HeightReset = 13'd480;
  localparam logic [ScaleW-1:0] ScaleReset  = 24'd2184;
  localparam logic [AxisW-1:0]  RightReset  = 63'd524288;
  localparam logic [AxisW-1:0]  UpReset     = 63'd274877906944;
  localparam logic [AxisW-1:0]  BackReset   = 63'd144115188075855872;

  // Subpixel offset in eighths of a pixel.
  typedef struct packed {
    logic signed [2:0] sx;
    logic signed [2:0] sy;
  } ofs_t;

  // Number of rays a mode produces; the unused mode produces none.
  function automatic logic [IdxW-1:0] run_length(input logic [OpW-1:0] op);
    logic [IdxW-1:0] n;
    unique case (op)
      OP_CENTRE: n = 4'd1;
      OP_CORNER: n = 4'd4;
      OP_GRID:   n = 4'd12;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // Offset of sample idx within a run of the given mode.
  function automatic ofs_t sample_ofs(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx);
    ofs_t o;
    o = '{sx: 3'sd0, sy: 3'sd0};
    if (op == OP_CORNER) begin
      unique case (idx[1:0])
        2'd0:    o = '{sx: -3'sd3, sy: -3'sd3};
        2'd1:    o = '{sx:  3'sd3, sy: -3'sd3};
        2'd2:    o = '{sx: -3'sd3, sy:  3'sd3};
        default: o = '{sx:  3'sd3, sy:  3'sd3};
      endcase
    end else if (op == OP_GRID) begin
      unique case (idx)
        4'd0:    o = '{sx: -3'sd1, sy: -3'sd3};
        4'd1:    o = '{sx:  3'sd1, sy: -3'sd3};
        4'd2:    o = '{sx: -3'sd3, sy: -3'sd1};
        4'd3:    o = '{sx: -3'sd1, sy: -3'sd1};
        4'd4:    o = '{sx:  3'sd1, sy: -3'sd1};
        4'd5:    o = '{sx:  3'sd3, sy: -3'sd1};
        4'd6:    o = '{sx: -3'sd3, sy:  3'sd1};
        4'd7:    o = '{sx: -3'sd1, sy:  3'sd1};
        4'd8:    o = '{sx:  3'sd1, sy:  3'sd1};
        4'd9:    o = '{sx:  3'sd3, sy:  3'sd1};
        4'd10:   o = '{sx: -3'sd1, sy:  3'sd3};
        default: o = '{sx:  3'sd1, sy:  3'sd3};
      endcase
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: src/pcrg_req_if.sv
// Request channel of the ray generator: mode and pixel coordinate.
// Depends on pcrg_pkg.
`default_nettype none

interface pcrg_req_if import pcrg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;

  modport source (output valid, output op, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input op, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

FILE: src/pcrg_ray_if.sv
// Result channel of the ray generator: one ray direction per sample of a request.
// Depends on pcrg_pkg.
`default_nettype none

interface pcrg_ray_if import pcrg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [DirW-1:0] dir_x;
  logic signed [DirW-1:0] dir_y;
  logic signed [DirW-1:0] dir_z;
  logic [IdxW-1:0]        sample_index;
  logic                   saturated;
  logic                   last;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output sample_index, output saturated, output last, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                  input sample_index, input saturated, input last, output ready);
endinterface

`default_nettype wire

FILE: src/pcrg_cfg_if.sv
// Configuration write channel of the ray generator: register index and data.
// Depends on pcrg_pkg.
`default_nettype none

interface pcrg_cfg_if import pcrg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/pinhole_camera_ray_generator_unit.sv
// Top level of the pinhole camera ray generator: configuration registers,
// sample sequencer and six-stage direction pipeline.
// Depends on pcrg_pkg, pcrg_req_if, pcrg_ray_if and pcrg_cfg_if.
`default_nettype none

// A request carries a mode and a pixel; the block answers with 1 (centre),
// 4 (corners) or 12 (remaining 4x4 grid) ray directions, in that fixed
// order, each computed as -back + scale*(u*right + v*up), rounded to Q11.20
// and clamped with a flag. A sequencer issues one sample per cycle, unless
// the pipeline is halted, into a six-stage pipeline; a new request is
// taken in the cycle its last sample issues, and mode 3 is taken and
// yields nothing. The whole pipeline halts while a finished ray waits on
// the result channel. Configuration writes take effect at once and are
// meant to arrive only while the block is idle.
module pinhole_camera_ray_generator_unit import pcrg_pkg::*; #(
  parameter int MAX_DIM        = MaxDimDefault,
  parameter int AXIS_FRAC_BITS = AxisFracDefault
) (
  input  logic      clk,
  input  logic      rst,
  pcrg_cfg_if.sink  cfg,
  pcrg_req_if.sink  req,
  pcrg_ray_if.source ray
);

  localparam logic [DimW-1:0] DimCap = (MAX_DIM > 8191) ? 13'h1FFF : DimW'(MAX_DIM);
  localparam int RoundShift = AXIS_FRAC_BITS + SubFrac;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(64'sd1 <<< (RoundShift - 1));
  localparam logic signed [SumW-1:0] DirMax = 64'sd2147483647;
  localparam logic signed [SumW-1:0] DirMin = -64'sd2147483648;

  // Configuration registers.
  logic [DimW-1:0]   image_width;
  logic [DimW-1:0]   image_height;
  logic [ScaleW-1:0] view_scale;
  logic [AxisW-1:0]  axis_right;
  logic [AxisW-1:0]  axis_up;
  logic [AxisW-1:0]  axis_back;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WidthReset;
      image_height <= HeightReset;
      view_scale   <= ScaleReset;
      axis_right   <= RightReset;
      axis_up      <= UpReset;
      axis_back    <= BackReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[DimW-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[DimW-1:0];
        REG_VIEW_SCALE:   view_scale   <= cfg.data[ScaleW-1:0];
        REG_AXIS_RIGHT:   axis_right   <= cfg.data[AxisW-1:0];
        REG_AXIS_UP:      axis_up      <= cfg.data[AxisW-1:0];
        REG_AXIS_BACK:    axis_back    <= cfg.data[AxisW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless a finished ray is held.
  logic en;
  logic s6_valid;
  assign en = !s6_valid || ray.ready;

  // Effective dimensions, clamped to one and to the maximum.
  logic [DimW-1:0] width_eff;
  logic [DimW-1:0] height_eff;

  always_comb begin
    if (image_width == '0) begin
      width_eff = 13'd1;
    end else if (image_width > DimCap) begin
      width_eff = DimCap;
    end else begin
      width_eff = image_width;
    end
    if (image_height == '0) begin
      height_eff = 13'd1;
    end else if (image_height > DimCap) begin
      height_eff = DimCap;
    end else begin
      height_eff = image_height;
    end
  end

  // Pixel centre relative to the image centre, in eighths of a pixel.
  logic signed [PosW-1:0] base_u;
  logic signed [PosW-1:0] base_v;
  assign base_u = $signed({2'b00, req.pixel_x, 3'b100}) - $signed({2'b00, width_eff, 2'b00});
  assign base_v = $signed({2'b00, req.pixel_y, 3'b100}) - $signed({2'b00, height_eff, 2'b00});

  // Sample sequencer: holds one request and issues its samples in order.
  logic                   busy;
  logic [OpW-1:0]         seq_op;
  logic [IdxW-1:0]        seq_idx;
  logic [IdxW-1:0]        seq_len;
  logic signed [PosW-1:0] seq_u0;
  logic signed [PosW-1:0] seq_v0;
  logic                   seq_last;
  logic                   issue;
  ofs_t                   seq_ofs;

  assign seq_last  = (seq_idx == seq_len - 4'd1);
  assign issue     = busy && en;
  assign req.ready = en && (!busy || seq_last);
  assign seq_ofs   = sample_ofs(seq_op, seq_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.valid && req.ready) begin
      busy <= (run_length(req.op) != '0);
    end else if (issue && seq_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      seq_op  <= req.op;
      seq_len <= run_length(req.op);
      seq_idx <= '0;
      seq_u0  <= base_u;
      seq_v0  <= base_v;
    end else if (issue && !seq_last) begin
      seq_idx <= seq_idx + 4'd1;
    end
  end

  // Stage 1: subpixel position of the sample.
  logic                   s1_valid;
  logic signed [PosW-1:0] s1_u;
  logic signed [PosW-1:0] s1_v;
  logic [IdxW-1:0]        s1_idx;
  logic                   s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u    <= seq_u0 + PosW'(seq_ofs.sx);
      s1_v    <= seq_v0 + PosW'(seq_ofs.sy);
      s1_idx  <= seq_idx;
      s1_last <= seq_last;
    end
  end

  // Stage 2: position times view scale.
  logic                    s2_valid;
  logic signed [ProdW-1:0] s2_su;
  logic signed [ProdW-1:0] s2_sv;
  logic [IdxW-1:0]         s2_idx;
  logic                    s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_su   <= $signed({1'b0, view_scale}) * s1_u;
      s2_sv   <= $signed({1'b0, view_scale}) * s1_v;
      s2_idx  <= s1_idx;
      s2_last <= s1_last;
    end
  end

  // Stage 3: axis components times the scaled position, in two partial
  // products each (upper signed half and lower unsigned half).
  localparam int LoW = CompW;
  localparam int HiW = ProdW - LoW;

  logic                                  s3_valid;
  logic signed [CompW+HiW-1:0]           s3_rh [3];
  logic signed [CompW+LoW:0]             s3_rl [3];
  logic signed [CompW+HiW-1:0]           s3_uh [3];
  logic signed [CompW+LoW:0]             s3_ul [3];
  logic [IdxW-1:0]                       s3_idx;
  logic                                  s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_rh[k] <= $signed(axis_right[CompW*k +: CompW]) * $signed(s2_su[ProdW-1:LoW]);
        s3_rl[k] <= $signed(axis_right[CompW*k +: CompW]) * $signed({1'b0, s2_su[LoW-1:0]});
        s3_uh[k] <= $signed(axis_up[CompW*k +: CompW]) * $signed(s2_sv[ProdW-1:LoW]);
        s3_ul[k] <= $signed(axis_up[CompW*k +: CompW]) * $signed({1'b0, s2_sv[LoW-1:0]});
      end
      s3_idx  <= s2_idx;
      s3_last <= s2_last;
    end
  end

  // Stage 4: recombine the partial products.
  logic                   s4_valid;
  logic signed [SumW-1:0] s4_pr [3];
  logic signed [SumW-1:0] s4_pu [3];
  logic [IdxW-1:0]        s4_idx;
  logic                   s4_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_pr[k] <= (SumW'(s3_rh[k]) <<< LoW) + SumW'(s3_rl[k]);
        s4_pu[k] <= (SumW'(s3_uh[k]) <<< LoW) + SumW'(s3_ul[k]);
      end
      s4_idx  <= s3_idx;
      s4_last <= s3_last;
    end
  end

  // Stage 5: exact sum with the back axis subtracted.
  logic                   s5_valid;
  logic signed [SumW-1:0] s5_sum [3];
  logic [IdxW-1:0]        s5_idx;
  logic                   s5_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s5_sum[k] <= s4_pr[k] + s4_pu[k]
                   - (SumW'($signed(axis_back[CompW*k +: CompW])) <<< BackShift);
      end
      s5_idx  <= s4_idx;
      s5_last <= s4_last;
    end
  end

  // Stage 6: round half up to Q11.20 and clamp; this is the output register.
  logic signed [SumW-1:0] rnd_q [3];
  logic signed [DirW-1:0] sat_q [3];
  logic [2:0]             clamp;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd_q[k] = (s5_sum[k] + RoundHalf) >>> RoundShift;
      if (rnd_q[k] > DirMax) begin
        sat_q[k] = DirMax[DirW-1:0];
        clamp[k] = 1'b1;
      end else if (rnd_q[k] < DirMin) begin
        sat_q[k] = DirMin[DirW-1:0];
        clamp[k] = 1'b1;
      end else begin
        sat_q[k] = rnd_q[k][DirW-1:0];
        clamp[k] = 1'b0;
      end
    end
  end

  logic signed [DirW-1:0] s6_dir [3];
  logic                   s6_sat;
  logic [IdxW-1:0]        s6_idx;
  logic                   s6_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s6_dir[k] <= sat_q[k];
      end
      s6_sat  <= |clamp;
      s6_idx  <= s5_idx;
      s6_last <= s5_last;
    end
  end

  assign ray.valid        = s6_valid;
  assign ray.dir_x        = s6_dir[0];
  assign ray.dir_y        = s6_dir[1];
  assign ray.dir_z        = s6_dir[2];
  assign ray.sample_index = s6_idx;
  assign ray.saturated    = s6_sat;
  assign ray.last         = s6_last;

  // A new request is only taken while the held one issues its last sample.
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && busy) |-> (seq_last && issue))
    else $error("request taken while samples of the previous one remain");

  // The sample counter stays inside the run.
  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (seq_idx < seq_len))
    else $error("sample counter ran past the end of the run");

  // The final ray of a run carries the index of a run end.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (ray.valid && ray.last) |->
      (ray.sample_index == 4'd0 || ray.sample_index == 4'd3 || ray.sample_index == 4'd11))
    else $error("final ray of a run has an unexpected sample index");

  // A stalled pipeline keeps its samples in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !en) |=> (s1_valid && $stable(s1_idx)))
    else $error("sample lost in the pipeline during a stall");

endmodule

`default_nettype wire
